// ===== sv/shsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shsd_pkg
// Shared types and constants of the half-step stepper driver.
// ----------------------------------------------------------------------------
package shsd_pkg;

  localparam int unsigned PhaseStepsDefault = 8;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned PatternW = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned SpeedW   = 3;
  localparam int unsigned CountW   = 8;
  localparam int unsigned TableW   = 3;

  // Item kinds
  localparam logic OpTick    = 1'b0;
  localparam logic OpCommand = 1'b1;

  // Command codes
  localparam logic [CodeW-1:0] CmdForward = 8'd1;
  localparam logic [CodeW-1:0] CmdReverse = 8'd2;
  localparam logic [CodeW-1:0] CmdFaster  = 8'd3;
  localparam logic [CodeW-1:0] CmdSlower  = 8'd4;

  // Run modes
  localparam logic [ModeW-1:0] ModeStop    = 2'd0;
  localparam logic [ModeW-1:0] ModeForward = 2'd1;
  localparam logic [ModeW-1:0] ModeReverse = 2'd2;

  // Speed levels
  localparam logic [SpeedW-1:0] SpeedMin = 3'd1;
  localparam logic [SpeedW-1:0] SpeedMax = 3'd5;

  // Step result handed from the sequencer core to the output stage
  typedef struct packed {
    logic                step;
    logic [PatternW-1:0] pattern;
  } step_t;

  function automatic logic [PatternW-1:0] fwd_pattern(input logic [TableW-1:0] idx);
    logic [PatternW-1:0] p;
    case (idx)
      3'd0:    p = 8'h80;
      3'd1:    p = 8'hc0;
      3'd2:    p = 8'h40;
      3'd3:    p = 8'h60;
      3'd4:    p = 8'h20;
      3'd5:    p = 8'h30;
      3'd6:    p = 8'h10;
      default: p = 8'h90;
    endcase
    return p;
  endfunction

  function automatic logic [PatternW-1:0] rev_pattern(input logic [TableW-1:0] idx);
    logic [PatternW-1:0] p;
    case (idx)
      3'd0:    p = 8'h90;
      3'd1:    p = 8'h10;
      3'd2:    p = 8'h30;
      3'd3:    p = 8'h20;
      3'd4:    p = 8'h60;
      3'd5:    p = 8'h40;
      3'd6:    p = 8'hc0;
      default: p = 8'h80;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== sv/stepper_half_step_driver_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_half_step_driver_top
// Half-step stepper sequencer: tick and command items in, coil patterns out.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries one item per handshake:
// operation_i = 0 is a time tick, 1 is a command in command_code_i
// (1 forward, 2 reverse, 3 faster, 4 slower, anything else stop).
// Output channel (out_valid_o / out_ready_i) carries coil_pattern_o, one item
// for each tick that makes a step; commands and non-stepping ticks give none.
// A result is valid in the cycle after its tick is accepted.
// Throughput: one item per cycle unless the output stalls; the state update is
// combinational logic ahead of one output register.
// in_ready_o is high whenever the output register is empty or is being taken
// in the same cycle, so a stalled receiver holds the pending result and
// blocks new items only while that result waits.
// Reset sets mode forward, speed 1, counter 0, phase 0, and an empty output.
// ----------------------------------------------------------------------------
module stepper_half_step_driver_top
  import shsd_pkg::*;
#(
  parameter int unsigned PHASE_STEPS = PhaseStepsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                operation_i,
  input  wire logic [CodeW-1:0]    command_code_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [PatternW-1:0]      coil_pattern_o
);

  logic                out_valid_q, out_valid_d;
  logic [PatternW-1:0] pattern_q;
  logic                accept;
  step_t               result;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  shsd_core #(
    .PHASE_STEPS (PHASE_STEPS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .operation_i    (operation_i),
    .command_code_i (command_code_i),
    .result_o       (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (result.step) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // load the pattern only when a step lands
  always_ff @(posedge clk_i) begin
    if (result.step) begin
      pattern_q <= result.pattern;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coil_pattern_o = pattern_q;

endmodule
`default_nettype wire

// ===== sv/shsd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shsd_core
// Mode, speed, tick counter and phase state; decides steps and coil patterns.
// ----------------------------------------------------------------------------
module shsd_core
  import shsd_pkg::*;
#(
  parameter int unsigned PHASE_STEPS = PhaseStepsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic             operation_i,
  input  wire logic [CodeW-1:0] command_code_i,
  output step_t                 result_o
);

  localparam int unsigned PhaseW = $clog2(PHASE_STEPS);
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(PHASE_STEPS - 1);

  logic [ModeW-1:0]  mode_q, mode_d;
  logic [SpeedW-1:0] speed_q, speed_d;
  logic [CountW-1:0] count_q, count_d;
  logic [PhaseW-1:0] phase_q, phase_d;

  logic [CountW-1:0] limit;
  logic [CountW-1:0] count_add;
  logic              step;
  logic [TableW-1:0] tbl_idx;

  assign tbl_idx = TableW'(phase_q);

  always_comb begin
    unique case (speed_q)
      3'd1:    limit = 8'd15;
      3'd2:    limit = 8'd10;
      3'd3:    limit = 8'd5;
      3'd4:    limit = 8'd1;
      default: limit = 8'd0;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    speed_d   = speed_q;
    count_d   = count_q;
    phase_d   = phase_q;
    step      = 1'b0;
    count_add = '0;
    if (accept_i) begin
      if (operation_i == OpCommand) begin
        unique case (command_code_i)
          CmdForward: mode_d = ModeForward;
          CmdReverse: mode_d = ModeReverse;
          CmdFaster:  if (speed_q < SpeedMax) speed_d = speed_q + 3'd1;
          CmdSlower:  if (speed_q > SpeedMin) speed_d = speed_q - 3'd1;
          default:    mode_d = ModeStop;
        endcase
      end else begin
        if (speed_q >= SpeedMin && speed_q < SpeedMax) begin
          count_add = count_q + 8'd2;
          step      = count_add > limit;
          count_d   = step ? '0 : count_add;
        end else begin
          // top speed: step every tick, let the counter run and wrap
          count_d = count_q + 8'd1;
          step    = 1'b1;
        end
        if (step) begin
          phase_d = (phase_q == PhaseLast) ? '0 : phase_q + PhaseW'(1);
        end
      end
    end
  end

  always_comb begin
    result_o.step = step;
    unique case (mode_q)
      ModeForward: result_o.pattern = fwd_pattern(tbl_idx);
      ModeReverse: result_o.pattern = rev_pattern(tbl_idx);
      default:     result_o.pattern = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeForward;
      speed_q <= SpeedMin;
      count_q <= '0;
      phase_q <= '0;
    end else begin
      mode_q  <= mode_d;
      speed_q <= speed_d;
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire

// ===== sim/stepper_half_step_driver_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_half_step_driver_top_tb
// Self-checking bench for the half-step stepper sequencer. Tick and command
// items go in over a valid/ready channel with random gaps. An item-level model
// of mode, speed, tick counter and phase predicts every coil item, and each
// item that comes out is compared in order against that prediction.
// ----------------------------------------------------------------------------
module stepper_half_step_driver_top_tb;
  import shsd_pkg::*;

  localparam int unsigned PhaseSteps = PhaseStepsDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  localparam logic [PatternW-1:0] FwdCoils [8] = '{8'h80, 8'hc0, 8'h40, 8'h60,
                                                   8'h20, 8'h30, 8'h10, 8'h90};
  localparam logic [PatternW-1:0] RevCoils [8] = '{8'h90, 8'h10, 8'h30, 8'h20,
                                                   8'h60, 8'h40, 8'hc0, 8'h80};

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                operation_i    = OpTick;
  logic [CodeW-1:0]    command_code_i = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [PatternW-1:0] coil_pattern_o;

  // model state
  logic [ModeW-1:0]    motor_mode;
  logic [SpeedW-1:0]   motor_speed;
  logic [CountW-1:0]   tick_total;
  logic [TableW-1:0]   phase_pos;

  logic [PatternW-1:0] coil_queue [$];
  int unsigned         error_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         tx_idle_pct = 0;
  int unsigned         rx_idle_pct = 0;

  stepper_half_step_driver_top #(
    .PHASE_STEPS(PhaseSteps)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .command_code_i(command_code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coil_pattern_o(coil_pattern_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic logic [CountW-1:0] step_threshold(input logic [SpeedW-1:0] speed);
    case (speed)
      3'd1:    return 8'd15;
      3'd2:    return 8'd10;
      3'd3:    return 8'd5;
      3'd4:    return 8'd1;
      default: return 8'd0;
    endcase
  endfunction

  // Update the model for one accepted item; report whether it makes a step.
  function automatic void advance_motor(input logic op, input logic [CodeW-1:0] code,
                                        output logic stepped,
                                        output logic [PatternW-1:0] coils);
    stepped = 1'b0;
    coils   = '0;
    if (op == OpCommand) begin
      case (code)
        CmdForward: motor_mode = ModeForward;
        CmdReverse: motor_mode = ModeReverse;
        CmdFaster:  if (motor_speed < SpeedMax) motor_speed = motor_speed + 1'b1;
        CmdSlower:  if (motor_speed > SpeedMin) motor_speed = motor_speed - 1'b1;
        default:    motor_mode = ModeStop;
      endcase
      return;
    end
    if (motor_speed >= SpeedMin && motor_speed < SpeedMax) begin
      tick_total = tick_total + 8'd2;
      if (tick_total > step_threshold(motor_speed)) begin
        stepped    = 1'b1;
        tick_total = '0;
      end
    end else begin
      // top speed: step on every tick, let the counter wrap
      tick_total = tick_total + 8'd1;
      stepped    = 1'b1;
    end
    if (stepped) begin
      if (motor_mode == ModeForward) coils = FwdCoils[phase_pos];
      else if (motor_mode == ModeReverse) coils = RevCoils[phase_pos];
      if (int'(phase_pos) + 1 >= PhaseSteps) phase_pos = '0;
      else phase_pos = phase_pos + 1'b1;
    end
  endfunction

  task automatic send_item(input logic op, input logic [CodeW-1:0] code);
    logic                took;
    logic                stepped;
    logic [PatternW-1:0] coils;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    command_code_i <= code;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    advance_motor(op, code, stepped, coils);
    if (stepped) coil_queue.push_back(coils);
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(OpTick, '0);
  endtask

  task automatic send_command(input logic [CodeW-1:0] code, input int unsigned count);
    repeat (count) send_item(OpCommand, code);
  endtask

  // Compare on the falling edge; valid and ready are settled until the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (coil_queue.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < MaxReports)
          $display("unexpected coil item %h", coil_pattern_o);
      end else begin
        if (coil_pattern_o !== coil_queue[0]) begin
          error_count <= error_count + 1;
          if (error_count < MaxReports)
            $display("coil mismatch: expected %h, got %h", coil_queue[0], coil_pattern_o);
        end
        void'(coil_queue.pop_front());
      end
    end
  end

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  task automatic test_directed_cases();
    send_command(CmdFaster, 5);    // saturate at top speed
    send_ticks(2);
    send_command(CmdReverse, 1);
    send_ticks(1);
    send_command(8'h00, 1);        // stop, coils go to zero
    send_ticks(1);
    send_command(8'hff, 1);
    send_ticks(1);
    send_command(CmdForward, 1);
    send_command(CmdSlower, 5);    // saturate at slowest
    send_ticks(5);
    send_command(CmdFaster, 3);
    send_ticks(1);
  endtask

  task automatic test_counter_wrap();
    int unsigned turn_at;
    turn_at = $urandom_range(50, 250);
    send_command(CmdFaster, 4);
    for (int unsigned i = 0; i < 300; i++) begin
      if (i == turn_at) send_command(CmdReverse, 1);
      send_item(OpTick, '0);
    end
    // compare the wrapped count at a slower level
    send_command(CmdSlower, $urandom_range(1, 4));
    send_ticks(20);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned         pick;
    logic [CodeW-1:0]    code;
    repeat (count) begin
      if ($urandom_range(99) < 70) begin
        // ticks carry a random code byte that must be ignored
        send_item(OpTick, CodeW'($urandom_range(255)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 28) code = CmdFaster;
        else if (pick < 52) code = CmdSlower;
        else if (pick < 72) code = CmdForward;
        else if (pick < 88) code = CmdReverse;
        else if (pick < 94) code = CodeW'($urandom_range(5, 255));
        else code = CodeW'($urandom_range(255));
        send_item(OpCommand, code);
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (coil_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    motor_mode  = ModeForward;
    motor_speed = SpeedMin;
    tick_total  = '0;
    phase_pos   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(21, 47);
    test_directed_cases();
    test_counter_wrap();
    test_random_traffic(450);
    set_idling(47, 21);
    test_random_traffic(450);
    set_idling(0, 0);
    test_random_traffic(450);
    drain_results();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
